/* hdl/arpc_pkg.sv */
// arpc_pkg: shared types and codes for the ARP address cache.
// No dependencies; imported by every module of the block.
package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  localparam logic REQ_LEARN  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [1:0] OUTCOME_UPDATED  = 2'd0;
  localparam logic [1:0] OUTCOME_APPENDED = 2'd1;
  localparam logic [1:0] OUTCOME_DROPPED  = 2'd2;
  localparam logic [1:0] OUTCOME_LOOKUP   = 2'd3;

  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_wr_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_rd_t;

endpackage

/* hdl/arpc_table.sv */
// arpc_table: entry store, one write port and one registered read port.
// Depends on arpc_pkg.
module arpc_table
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic           clk,
  input  arpc_wr_t       wr,
  input  logic [IW-1:0]  wr_addr,
  input  logic [IW-1:0]  rd_addr,
  output arpc_rd_t       rd
);

  logic [IP_W-1:0]  mem_ip  [ENTRIES];
  logic [MAC_W-1:0] mem_mac [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ip[wr_addr]  <= wr.ip;
      mem_mac[wr_addr] <= wr.mac;
    end
  end

  always_ff @(posedge clk) begin
    rd.ip  <= mem_ip[rd_addr];
    rd.mac <= mem_mac[rd_addr];
  end

endmodule

/* hdl/arpc_seq.sv */
// arpc_seq: request sequencer; scans the table one entry per cycle through
// a single address comparator, then updates, appends, drops or reports.
// Depends on arpc_pkg.
module arpc_seq
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CW      = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             req_type,
  input  logic [IP_W-1:0]  ip_addr,
  input  logic [MAC_W-1:0] mac_addr,
  output logic             done,
  output logic             found,
  output logic [MAC_W-1:0] mac_out,
  output logic [1:0]       learn_outcome,
  output arpc_wr_t         wr,
  output logic [IW-1:0]    wr_addr,
  output logic [IW-1:0]    rd_addr,
  input  arpc_rd_t         rd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    issue_idx;
  logic [IW-1:0]    cmp_idx;
  logic             cmp_valid;
  logic             hit;
  logic [IW-1:0]    hit_idx;
  logic [MAC_W-1:0] hit_mac;
  logic             req_lookup;
  logic [IP_W-1:0]  req_ip;
  logic [MAC_W-1:0] req_mac;

  logic match;
  logic issue;
  logic room;

  assign busy    = (state != ST_IDLE);
  assign match   = cmp_valid && (rd.ip == req_ip);
  assign issue   = (state == ST_SCAN) && !match && (issue_idx < count);
  assign rd_addr = issue_idx[IW-1:0];
  assign room    = (count < CW'(ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (match || !issue) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // table write on the finishing cycle of a learn that hits or finds room
  always_comb begin
    wr.en   = 1'b0;
    wr.ip   = req_ip;
    wr.mac  = req_mac;
    wr_addr = hit ? hit_idx : count[IW-1:0];
    if (state == ST_FINISH && req_lookup == REQ_LEARN && (hit || room)) wr.en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      done      <= (state == ST_FINISH);
      if (wr.en && !hit) count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_lookup <= req_type;
      req_ip     <= ip_addr;
      req_mac    <= mac_addr;
      issue_idx  <= '0;
      hit        <= 1'b0;
    end
    if (issue) begin
      issue_idx <= issue_idx + CW'(1);
      cmp_idx   <= issue_idx[IW-1:0];
    end
    if (state == ST_SCAN && match) begin
      hit     <= 1'b1;
      hit_idx <= cmp_idx;
      hit_mac <= rd.mac;
    end
    if (state == ST_FINISH) begin
      found   <= hit;
      mac_out <= (req_lookup == REQ_LOOKUP && hit) ? hit_mac : '0;
      if (req_lookup == REQ_LOOKUP) learn_outcome <= OUTCOME_LOOKUP;
      else if (hit)                 learn_outcome <= OUTCOME_UPDATED;
      else if (room)                learn_outcome <= OUTCOME_APPENDED;
      else                          learn_outcome <= OUTCOME_DROPPED;
    end
  end

endmodule

/* hdl/arp_address_cache_top.sv */
// arp_address_cache_top: IPv4 to MAC address cache, learn and lookup.
// Depends on arpc_pkg, arpc_table and arpc_seq.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------
//  request  | start / busy      | req_type, ip_addr, mac_addr
//  result   | done (1 cycle)    | found, mac_out, learn_outcome
//
// A request passes from transfer through the scan of the stored entries and a
// finishing state before done is registered; a match ends the scan early.
// The scan reads one entry per cycle from the table port and checks it in
// the single address comparator. The next request may be started in the
// cycle done is high. rst is synchronous and empties the table. The result
// is shown for one cycle only; the receiver cannot stall.
module arp_address_cache_top
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             req_type,
  input  logic [IP_W-1:0]  ip_addr,
  input  logic [MAC_W-1:0] mac_addr,
  output logic             done,
  output logic             found,
  output logic [MAC_W-1:0] mac_out,
  output logic [1:0]       learn_outcome
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  arpc_wr_t      wr;
  arpc_rd_t      rd;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  arpc_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .ip_addr       (ip_addr),
    .mac_addr      (mac_addr),
    .done          (done),
    .found         (found),
    .mac_out       (mac_out),
    .learn_outcome (learn_outcome),
    .wr            (wr),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .rd            (rd)
  );

  arpc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (mac_out == '0))
    else $error("non-zero MAC without a hit");
  a_update_found: assert property (@(posedge clk) disable iff (rst)
    (done && (learn_outcome == OUTCOME_UPDATED || learn_outcome == OUTCOME_APPENDED))
      |-> (found == (learn_outcome == OUTCOME_UPDATED)))
    else $error("learn outcome and found disagree");
`endif

endmodule
